>>> hw/rtl/dijkstra_shortest_distance_assert.svh
// assertion macros shared by the shortest-distance checker
// expects signals named clk and rst in the scope of use
`ifndef DIJKSTRA_SHORTEST_DISTANCE_ASSERT_SVH
`define DIJKSTRA_SHORTEST_DISTANCE_ASSERT_SVH

// same-cycle implication
`define DSD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dsd_pkg.sv
// shared types and constants of the shortest-distance engine
// no dependencies
package dsd_pkg;

  localparam int NODE_FW   = 5;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 22;
  localparam int CFG_W     = 6;
  localparam int STATUS_W  = 2;

  localparam logic [WEIGHT_W-1:0] NO_EDGE          = '1;
  localparam logic [DIST_W-1:0]   DIST_MAX         = '1;
  localparam logic [CFG_W-1:0]    NODE_COUNT_RESET = 6'd32;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNREACH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [NODE_FW-1:0]  first_node;
    logic [NODE_FW-1:0]  second_node;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance;
  } out_item_t;

  typedef enum logic [1:0] {
    K_ADD   = 2'd0,
    K_QUERY = 2'd1,
    K_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [NODE_FW-1:0]  node_a;
    logic [NODE_FW-1:0]  node_b;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

endpackage

>>> hw/rtl/dsd_ram.sv
// generic single-port-write, single-port-read RAM with registered read
// no dependencies
module dsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/dsd_front.sv
// front end: accepts items, range-checks them and queues commands
// depends on dsd_pkg
module dsd_front import dsd_pkg::*; #(
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             hold,
  input  logic [CNT_W-1:0] n_eff,
  input  logic             push,
  input  in_item_t         item,
  output logic             full,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output cmd_t             cmd
);

  localparam int Q_DEPTH = 2;
  localparam int CW = (CNT_W > NODE_FW) ? CNT_W : NODE_FW;

  cmd_t       q [Q_DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;
  logic       bad_node;
  cmd_t       cmd_in;

  assign full      = hold || (cnt == 2'(Q_DEPTH));
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  assign bad_node = (CW'(item.first_node) >= CW'(n_eff)) ||
                    (CW'(item.second_node) >= CW'(n_eff));

  always_comb begin
    cmd_in.node_a = item.first_node;
    cmd_in.node_b = item.second_node;
    cmd_in.weight = item.edge_weight;
    if (bad_node) begin
      cmd_in.kind = K_ERROR;
    end else if (item.operation == OP_ADD) begin
      cmd_in.kind = K_ADD;
    end else begin
      cmd_in.kind = K_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/dsd_back.sv
// back end: weight matrix clearing, edge updates and the Dijkstra sequencer
// depends on dsd_pkg and dsd_ram
module dsd_back import dsd_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_NODES+1)-1:0]   n_eff,
  input  logic                             cmd_valid,
  input  cmd_t                             cmd,
  output logic                             cmd_ready,
  output logic                             clearing,
  input  logic                             pop,
  output logic                             result_valid,
  output out_item_t                        result
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DEPTH  = MAX_NODES * MAX_NODES;
  localparam int WA_W   = $clog2(DEPTH);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b0_0000_0001,
    S_IDLE    = 9'b0_0000_0010,
    S_ADD_RD  = 9'b0_0000_0100,
    S_ADD_CMP = 9'b0_0000_1000,
    S_ADD_WR  = 9'b0_0001_0000,
    S_CHECK   = 9'b0_0010_0000,
    S_PASS    = 9'b0_0100_0000,
    S_DRAIN   = 9'b0_1000_0000,
    S_OUT     = 9'b1_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [WA_W-1:0]     clr_cnt;
  logic [NODE_W-1:0]   a;
  logic [NODE_W-1:0]   b;
  logic [WEIGHT_W-1:0] wgt;
  logic                add_wr;
  logic [NODE_W-1:0]   best;
  logic [NODE_W-1:0]   dst;
  logic [DIST_W-1:0]   best_dist;
  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] settled;
  logic [NODE_W-1:0]   v;
  logic                s1_valid;
  logic [NODE_W-1:0]   s1_v;
  logic                s2_valid;
  logic [NODE_W-1:0]   s2_v;
  logic [DIST_W-1:0]   s2_d;
  logic                s2_live;
  logic                have;
  logic [NODE_W-1:0]   min_v;
  logic [DIST_W-1:0]   min_d;
  out_item_t           pend;
  out_item_t           res;
  logic                res_valid;

  // weight RAM
  logic                w_we;
  logic [WA_W-1:0]     w_waddr;
  logic [WEIGHT_W-1:0] w_wdata;
  logic [WA_W-1:0]     w_raddr;
  logic [WEIGHT_W-1:0] w_rdata;
  logic [NODE_W-1:0]   r_row;
  logic [NODE_W-1:0]   r_col;
  logic [NODE_W-1:0]   wr_row;
  logic [NODE_W-1:0]   wr_col;

  // distance RAM
  logic                d_we;
  logic [DIST_W-1:0]   d_rdata;

  // relax stage
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   cand;
  logic                upd;
  logic [DIST_W-1:0]   new_d;
  logic                new_live;
  logic                take;
  logic                last;
  logic                drained;
  logic                out_free;

  assign cmd_ready    = (state == S_IDLE);
  assign clearing     = (state == S_CLEAR);
  assign result_valid = res_valid;
  assign result       = res;
  assign out_free     = !res_valid || pop;
  assign last         = (CNT_W'(v) == n_eff - CNT_W'(1));
  assign drained      = !s1_valid && !s2_valid;

  // address rows and columns
  always_comb begin
    if (state == S_PASS) begin
      r_row = best;
      r_col = v;
    end else begin
      r_row = a;
      r_col = b;
    end
    if (state == S_ADD_WR) begin
      wr_row = b;
      wr_col = a;
    end else begin
      wr_row = a;
      wr_col = b;
    end
  end

  assign w_raddr = WA_W'(r_row) * WA_W'(MAX_NODES) + WA_W'(r_col);

  always_comb begin
    w_we    = 1'b0;
    w_waddr = WA_W'(wr_row) * WA_W'(MAX_NODES) + WA_W'(wr_col);
    w_wdata = wgt;
    case (state)
      S_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_cnt;
        w_wdata = NO_EDGE;
      end
      S_ADD_CMP: begin
        w_we = (wgt < w_rdata);
      end
      S_ADD_WR: begin
        w_we = add_wr;
      end
      default: begin
        w_we = 1'b0;
      end
    endcase
  end

  dsd_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (w_wdata),
    .rd_addr (w_raddr),
    .rd_data (w_rdata)
  );

  dsd_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_NODES)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (d_we),
    .wr_addr (s1_v),
    .wr_data (cand),
    .rd_addr (v),
    .rd_data (d_rdata)
  );

  // relax one neighbor of the node just settled
  always_comb begin
    sum      = {1'b0, best_dist} + (DIST_W+1)'(w_rdata);
    cand     = (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    upd      = s1_valid && (w_rdata != NO_EDGE) && !settled[s1_v] &&
               (!reached[s1_v] || (cand < d_rdata));
    new_d    = upd ? cand : d_rdata;
    new_live = (reached[s1_v] || upd) && !settled[s1_v];
    d_we     = upd;
  end

  // strict compare keeps the lowest node on ties
  assign take = s2_valid && s2_live && (!have || (s2_d < min_d));

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == WA_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_ADD:   state_next = S_ADD_RD;
            K_QUERY: state_next = S_CHECK;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_ADD_RD:  state_next = S_ADD_CMP;
      S_ADD_CMP: state_next = S_ADD_WR;
      S_ADD_WR:  state_next = S_OUT;
      S_CHECK: begin
        state_next = (best == dst) ? S_OUT : S_PASS;
      end
      S_PASS: begin
        if (last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drained) begin
          state_next = have ? S_CHECK : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      have      <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == S_PASS);
      s2_valid <= s1_valid;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + WA_W'(1);
      end
      if (state == S_CHECK) begin
        have <= 1'b0;
      end else if (take) begin
        have <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_v    <= v;
    s2_v    <= s1_v;
    s2_d    <= new_d;
    s2_live <= new_live;
    if (upd) begin
      reached[s1_v] <= 1'b1;
    end
    if (take) begin
      min_v <= s2_v;
      min_d <= s2_d;
    end
    case (state)
      S_IDLE: begin
        a         <= NODE_W'(cmd.node_a);
        b         <= NODE_W'(cmd.node_b);
        wgt       <= cmd.weight;
        best      <= NODE_W'(cmd.node_a);
        dst       <= NODE_W'(cmd.node_b);
        best_dist <= '0;
        settled   <= '0;
        reached   <= MAX_NODES'(1) << cmd.node_a;
        pend      <= '{status: ST_RANGE, distance: '0};
      end
      S_ADD_CMP: begin
        add_wr <= (wgt < w_rdata);
      end
      S_ADD_WR: begin
        pend <= '{status: ST_OK, distance: '0};
      end
      S_CHECK: begin
        if (best == dst) begin
          pend <= '{status: ST_OK, distance: best_dist};
        end else begin
          settled[best] <= 1'b1;
          v             <= '0;
        end
      end
      S_PASS: begin
        v <= v + NODE_W'(1);
      end
      S_DRAIN: begin
        if (drained) begin
          if (have) begin
            best      <= min_v;
            best_dist <= min_d;
          end else begin
            pend <= '{status: ST_UNREACH, distance: '0};
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          res <= pend;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/dijkstra_shortest_distance.sv
// top level of the single-pair shortest-distance engine
// depends on dsd_pkg, dsd_front, dsd_back (and dsd_ram below it)
//
// channel  dir  handshake            payload
// item     in   push / full          in_item_t
// result   out  pop / empty          out_item_t
// cfg      in   cfg_valid/cfg_ready  node_count, 6 bits
//
// after reset every weight RAM entry is swept to no-edge, with full held high
// add-edge: read, compare and write one direction, write the other, hand-off
// query: per settled node a check step, a sweep of n weight RAM reads and a drain of the
// relax pipeline, ending in the hand-off
// out-of-range item: straight to the hand-off; n is node_count clamped to MAX_NODES
// a two-entry command queue keeps taking items while the back end works or the result waits
// the back end stalls in its hand-off state until the single result register is popped
module dijkstra_shortest_distance import dsd_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  in_item_t         item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMPW  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] node_count;
  logic [CMPW-1:0]  nc_ext;
  logic [CNT_W-1:0] n_eff;
  logic             clearing;
  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  logic             result_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  assign nc_ext = CMPW'(node_count);
  assign n_eff  = (nc_ext > CMPW'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(nc_ext);

  dsd_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .n_eff     (n_eff),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dsd_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .n_eff        (n_eff),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready),
    .clearing     (clearing),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> hw/rtl/dsd_checker.sv
// port-level checks for the shortest-distance engine, bound to the top level
// depends on dsd_pkg and dijkstra_shortest_distance_assert.svh
`include "dijkstra_shortest_distance_assert.svh"

module dsd_checker import dsd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // just after reset, as the weight RAM sweep starts, nothing waits and nothing is taken
  `DSD_ASSERT_IMPL(a_reset_quiet, $past(rst), empty && full, "not quiet after reset")

  `DSD_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result lost")

  `DSD_ASSERT_IMPL(a_status_code, !empty, result.status <= ST_RANGE, "bad status")

  // only a good query or add carries a distance, and adds carry zero
  `DSD_ASSERT_IMPL(a_zero_dist, !empty && result.status != ST_OK, result.distance == '0, "distance on error")

endmodule

bind dijkstra_shortest_distance dsd_checker u_checker (.*);

>>> dv/dijkstra_shortest_distance_tb.sv
// self-checking testbench for the single-pair shortest-distance engine
// holds its own graph predictor, queue-style driver and monitor, and a watchdog
// depends on dsd_pkg and dijkstra_shortest_distance
module dijkstra_shortest_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsd_pkg::*;

  localparam int          MAX_NODES        = 32;
  localparam realtime     CLK_HALF         = 6ns;
  localparam int          WATCHDOG_LIMIT   = 20000;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          SETTLE_CYCLES    = 40;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             push      = 1'b0;
  in_item_t         item      = '0;
  logic             full;
  logic             empty;
  logic             pop       = 1'b0;
  out_item_t        result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  dijkstra_shortest_distance #(
    .MAX_NODES(MAX_NODES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // predictor state
  logic [WEIGHT_W-1:0] weight_matrix [MAX_NODES][MAX_NODES];
  logic [CFG_W-1:0]    node_count_cfg = NODE_COUNT_RESET;

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  logic        in_long_hold       = 1'b0;
  event        start_long_hold;
  int          mismatch_count     = 0;
  int          results_checked    = 0;
  int          quiet_cycles       = 0;

  function automatic int unsigned nodes_in_use(logic [CFG_W-1:0] count);
    return (count > MAX_NODES) ? MAX_NODES : int'(count);
  endfunction

  // applies one item to the graph copy and returns the result it should give
  function automatic out_item_t predict_distance(in_item_t it);
    int unsigned         n;
    int unsigned         best;
    int unsigned         src;
    int unsigned         dst;
    logic [DIST_W-1:0]   dist_of [MAX_NODES];
    bit                  reached [MAX_NODES];
    bit                  settled [MAX_NODES];
    logic [WEIGHT_W-1:0] w;
    logic [DIST_W:0]     sum;
    logic [DIST_W-1:0]   cand;
    bit                  searching;
    out_item_t           r;
    r   = '0;
    n   = nodes_in_use(node_count_cfg);
    src = it.first_node;
    dst = it.second_node;
    if (src >= n || dst >= n) begin
      r.status = ST_RANGE;
      return r;
    end
    if (it.operation == OP_ADD) begin
      if (it.edge_weight < weight_matrix[src][dst]) weight_matrix[src][dst] = it.edge_weight;
      if (it.edge_weight < weight_matrix[dst][src]) weight_matrix[dst][src] = it.edge_weight;
      return r;
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      dist_of[i] = '0;
      reached[i] = 1'b0;
      settled[i] = 1'b0;
    end
    reached[src] = 1'b1;
    searching = 1'b1;
    while (searching) begin
      best = n;
      // strict compare keeps the lowest node number on ties
      for (int i = 0; i < n; i++) begin
        if (reached[i] && !settled[i] && (best == n || dist_of[i] < dist_of[best])) best = i;
      end
      if (best == n || best == dst) begin
        searching = 1'b0;
      end else begin
        settled[best] = 1'b1;
        for (int v = 0; v < n; v++) begin
          w = weight_matrix[best][v];
          if (w != NO_EDGE && !settled[v]) begin
            sum  = {1'b0, dist_of[best]} + w;
            cand = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
            if (!reached[v] || cand < dist_of[v]) begin
              reached[v] = 1'b1;
              dist_of[v] = cand;
            end
          end
        end
      end
    end
    if (reached[dst]) r.distance = dist_of[dst];
    else r.status = ST_UNREACH;
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("result %0d: %s got %0d, predicted %0d", results_checked, field, got, want);
  endtask

  // sender side: offers the head of the pending queue
  always @(negedge clk) begin
    if (!rst && pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      push <= 1'b1;
      item <= pending_items[0];
    end else begin
      push <= 1'b0;
    end
  end

  // input transfer: predict at acceptance so graph updates follow block order
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      expected_results = {expected_results, predict_distance(item)};
      void'(pending_items.pop_front());
    end
  end

  always @(negedge clk) begin
    pop <= !rst && !in_long_hold && ($urandom_range(99) >= receiver_stall_pct);
  end

  always begin
    @(start_long_hold);
    in_long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    in_long_hold = 1'b0;
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && pop && !empty) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", result.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
        if (result.distance !== want.distance)
          report_mismatch("distance", result.distance, want.distance);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_item(logic op, logic [NODE_FW-1:0] a, logic [NODE_FW-1:0] b,
                            logic [WEIGHT_W-1:0] w);
    in_item_t it;
    it.operation   = op;
    it.first_node  = a;
    it.second_node = b;
    it.edge_weight = w;
    pending_items = {pending_items, it};
  endtask

  task automatic wait_for_drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    node_count_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range nodes, now and then any 5-bit value
  function automatic logic [NODE_FW-1:0] pick_node(int unsigned n);
    if (n == 0 || $urandom_range(9) == 0) return NODE_FW'($urandom);
    return NODE_FW'($urandom_range(n - 1));
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NO_EDGE - 1'b1;
      2:       return NO_EDGE;
      3, 4:    return WEIGHT_W'($urandom_range(65535));
      default: return WEIGHT_W'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic run_phase(logic [CFG_W-1:0] count, int unsigned idle_pct,
                           int unsigned stall_pct, int num_items, bit long_hold);
    int unsigned n;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_node_count(count);
    n = nodes_in_use(count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    if (long_hold) -> start_long_hold;
    repeat (num_items) begin
      queue_item(($urandom_range(99) < 55) ? OP_ADD : OP_QUERY,
                 pick_node(n), pick_node(n), pick_weight());
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_NODES; i++)
      for (int j = 0; j < MAX_NODES; j++) weight_matrix[i][j] = NO_EDGE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset node count
    queue_item(OP_QUERY, 5'd0,  5'd31, 16'd0);      // empty graph
    queue_item(OP_QUERY, 5'd5,  5'd5,  16'hFFFF);   // source is destination
    queue_item(OP_ADD,   5'd0,  5'd1,  16'd0);
    queue_item(OP_ADD,   5'd1,  5'd2,  16'd65534);
    queue_item(OP_ADD,   5'd1,  5'd2,  NO_EDGE);    // no-edge weight leaves it alone
    queue_item(OP_ADD,   5'd0,  5'd1,  16'd100);    // heavier repeat keeps the lighter edge
    queue_item(OP_ADD,   5'd3,  5'd3,  16'd7);      // self loop
    queue_item(OP_QUERY, 5'd0,  5'd2,  16'd0);
    queue_item(OP_QUERY, 5'd2,  5'd0,  16'hFFFF);
    queue_item(OP_QUERY, 5'd3,  5'd3,  16'd0);
    queue_item(OP_ADD,   5'd2,  5'd31, 16'd65534);
    queue_item(OP_QUERY, 5'd0,  5'd31, 16'd0);
    queue_item(OP_QUERY, 5'd31, 5'd0,  16'd0);
    queue_item(OP_ADD,   5'd4,  5'd5,  16'd10);     // two equal routes
    queue_item(OP_ADD,   5'd4,  5'd6,  16'd10);
    queue_item(OP_ADD,   5'd5,  5'd7,  16'd1);
    queue_item(OP_ADD,   5'd6,  5'd7,  16'd1);
    queue_item(OP_QUERY, 5'd4,  5'd7,  16'd0);
    queue_item(OP_ADD,   5'd3,  5'd8,  NO_EDGE);
    queue_item(OP_QUERY, 5'd3,  5'd8,  16'd0);      // self loop does not help

    run_phase(6'd6,  0,  0,  120, 1'b0);
    run_phase(6'd10, 46, 0,  120, 1'b0);
    run_phase(6'd4,  0,  46, 100, 1'b1);  // long receiver hold fills the block
    run_phase(6'd0,  34, 34, 10,  1'b0);  // every node out of range
    run_phase(6'd63, 34, 34, 50,  1'b0);  // clamps to the full node set
    run_phase(6'd1,  0,  0,  20,  1'b0);
    run_phase(6'd16, 34, 34, 100, 1'b0);  // edges above the count stay but are ignored
    run_phase(6'd32, 46, 46, 30,  1'b1);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dsd_pkg.sv
hw/rtl/dsd_ram.sv
hw/rtl/dsd_front.sv
hw/rtl/dsd_back.sv
hw/rtl/dijkstra_shortest_distance.sv
hw/rtl/dsd_checker.sv
dv/dijkstra_shortest_distance_tb.sv
